// ----- rtl/core/table_driven_fsm_engine_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the table driven state machine engine
// Concurrent checks clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_FSM_ENGINE_CORE_MACROS_SVH
`define TABLE_DRIVEN_FSM_ENGINE_CORE_MACROS_SVH

// check a condition at every edge
`define TFE_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");

// check a consequence in the cycle after its trigger
`define TFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/core/tfe_pkg.sv -----
// ---------------------------------------------------------------------------
// tfe_pkg
// Types and codes used by the state machine engine and its table entries.
// ---------------------------------------------------------------------------
package tfe_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  localparam logic [1:0] REG_TABLE_SIZE    = 2'd0;
  localparam logic [1:0] REG_DEFAULT_STATE = 2'd1;
  localparam logic [1:0] REG_DEFAULT_EVENT = 2'd2;

  typedef struct packed {
    logic       has_handler;
    logic       stays;
    logic [3:0] to_state;
    logic [7:0] event_id;
    logic [3:0] from_state;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic       fired;
    logic       is_start;
    logic [4:0] entry_used;
    logic [3:0] old_state;
    logic [3:0] new_state;
    logic       state_changed;
    logic       run_handler;
    logic       chain_overflow;
    logic       last;
  } result_t;

endpackage

// ----- rtl/core/tfe_ram.sv -----
// ---------------------------------------------------------------------------
// tfe_ram
// Generic single write, single read RAM with a registered read port.
// ---------------------------------------------------------------------------
module tfe_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/table_driven_fsm_engine_core.sv -----
// ---------------------------------------------------------------------------
// table_driven_fsm_engine_core
// Programmable state machine: a transition table in RAM is searched for the
// current state and event, fired entries and default chains give results.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                word
//  in       sink       in_valid / in_stall      opcode and entry fields
//  out      source     out_valid / out_stall    one result of an item
//  cfg      APB slave  psel penable pwrite      table_size, default regs
//
//  A load writes the table RAM while the engine stays idle. A start or
//  event scans the table entry by entry through READ and CHECK (one RAM
//  read port, registered read); each result passes through EMIT, and FIRE
//  applies the matched entry. The table RAM is not cleared by reset.
//  Input stalls while an item is in work; output stalls hold the sequencer.
// ---------------------------------------------------------------------------
`include "table_driven_fsm_engine_core_macros.svh"

module table_driven_fsm_engine_core #(
  parameter int TABLE_DEPTH = 32,
  parameter int NUM_STATES  = 16,
  parameter int CHAIN_LIMIT = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [4:0]  entry_index,
  input  logic [3:0]  from_state,
  input  logic [7:0]  event_id,
  input  logic [3:0]  to_state,
  input  logic        stays,
  input  logic        has_handler,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        fired,
  output logic        is_start,
  output logic [4:0]  entry_used,
  output logic [3:0]  old_state,
  output logic [3:0]  new_state,
  output logic        state_changed,
  output logic        run_handler,
  output logic        chain_overflow,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DEPTH_CAP = (TABLE_DEPTH > 63) ? 63 : TABLE_DEPTH;
  localparam int CCW       = $clog2(CHAIN_LIMIT + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_FIRE  = 3'd4;

  logic [2:0]            st;
  logic [5:0]            table_size;
  logic [3:0]            default_state;
  logic [7:0]            default_event_id;
  logic [3:0]            cur;
  logic [7:0]            ev;
  logic                  in_chain;
  logic [CCW-1:0]        chain_cnt;
  logic [5:0]            scan_idx;
  logic [5:0]            ent_idx;
  tfe_pkg::entry_t       ent;
  tfe_pkg::result_t      pend;
  tfe_pkg::result_t      res;

  logic                  in_acc;
  logic                  cfg_wr;
  logic                  out_free;
  logic [5:0]            scan_n;
  logic [7:0]            ev_key;
  logic [3:0]            ds_eff;
  logic                  ent_stay;
  logic                  ram_we;
  logic [tfe_pkg::ENTRY_W-1:0] ram_wdata;
  logic [tfe_pkg::ENTRY_W-1:0] ram_rdata;
  tfe_pkg::entry_t       rd_ent;

  assign pready   = 1'b1;
  assign in_stall = (st != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid || !out_stall;

  assign scan_n   = (table_size > 6'(DEPTH_CAP)) ? 6'(DEPTH_CAP) : table_size;
  assign ev_key   = in_chain ? default_event_id : ev;
  assign ds_eff   = (32'(default_state) < NUM_STATES) ? default_state : 4'd0;
  assign ent_stay = ent.stays || !(32'(ent.to_state) < NUM_STATES);
  assign rd_ent   = tfe_pkg::entry_t'(ram_rdata);

  assign ram_we    = in_acc && (opcode == tfe_pkg::OP_LOAD) &&
                     (32'(entry_index) < TABLE_DEPTH);
  assign ram_wdata = {has_handler, stays, to_state, event_id, from_state};

  tfe_ram #(
    .WIDTH (tfe_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(entry_index)),
    .wdata (ram_wdata),
    .raddr (AW'(scan_idx)),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (paddr[3:2])
      tfe_pkg::REG_TABLE_SIZE:    prdata = {26'd0, table_size};
      tfe_pkg::REG_DEFAULT_STATE: prdata = {28'd0, default_state};
      tfe_pkg::REG_DEFAULT_EVENT: prdata = {24'd0, default_event_id};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size       <= 6'd0;
      default_state    <= 4'd0;
      default_event_id <= 8'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        tfe_pkg::REG_TABLE_SIZE:    table_size       <= pwdata[5:0];
        tfe_pkg::REG_DEFAULT_STATE: default_state    <= pwdata[3:0];
        tfe_pkg::REG_DEFAULT_EVENT: default_event_id <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      cur       <= 4'd0;
      in_chain  <= 1'b0;
      chain_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (st != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (in_acc) begin
            scan_idx  <= 6'd0;
            chain_cnt <= '0;
            ev        <= event_id;
            case (opcode)
              tfe_pkg::OP_START: begin
                pend     <= '{fired: 1'b1, is_start: 1'b1, entry_used: 5'd0,
                              old_state: cur, new_state: ds_eff,
                              state_changed: 1'b1, run_handler: 1'b0,
                              chain_overflow: 1'b0, last: 1'b0};
                cur      <= ds_eff;
                in_chain <= 1'b1;
                st       <= ST_READ;
              end
              tfe_pkg::OP_EVENT: begin
                in_chain <= 1'b0;
                st       <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          if (scan_idx >= scan_n) begin
            if (!in_chain) begin
              pend <= '{fired: 1'b0, is_start: 1'b0, entry_used: 5'd0,
                        old_state: cur, new_state: cur,
                        state_changed: 1'b0, run_handler: 1'b0,
                        chain_overflow: 1'b0, last: 1'b1};
            end else begin
              pend.last <= 1'b1;
            end
            st <= ST_EMIT;
          end else begin
            st <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (rd_ent.from_state == cur && rd_ent.event_id == ev_key) begin
            ent     <= rd_ent;
            ent_idx <= scan_idx;
            if (in_chain && 32'(chain_cnt) >= CHAIN_LIMIT) begin
              {pend.chain_overflow, pend.last} <= 2'b11;
              st                               <= ST_EMIT;
            end else if (in_chain) begin
              pend.last <= 1'b0;
              st        <= ST_EMIT;
            end else begin
              st <= ST_FIRE;
            end
          end else begin
            scan_idx <= scan_idx + 6'd1;
            st       <= ST_READ;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            res       <= pend;
            out_valid <= 1'b1;
            st        <= pend.last ? ST_IDLE : ST_FIRE;
          end
        end
        ST_FIRE: begin
          pend <= '{fired: 1'b1, is_start: 1'b0, entry_used: 5'(ent_idx),
                    old_state: cur, new_state: ent_stay ? cur : ent.to_state,
                    state_changed: !ent_stay, run_handler: ent.has_handler,
                    chain_overflow: 1'b0, last: 1'b0};
          if (!ent_stay) begin
            cur <= ent.to_state;
          end
          if (in_chain) begin
            chain_cnt <= chain_cnt + CCW'(1);
          end
          in_chain <= 1'b1;
          scan_idx <= 6'd0;
          st       <= ST_READ;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  assign fired          = res.fired;
  assign is_start       = res.is_start;
  assign entry_used     = res.entry_used;
  assign old_state      = res.old_state;
  assign new_state      = res.new_state;
  assign state_changed  = res.state_changed;
  assign run_handler    = res.run_handler;
  assign chain_overflow = res.chain_overflow;
  assign last           = res.last;

  `TFE_ASSERT_NEXT(a_start_enters_chain, in_acc && opcode == tfe_pkg::OP_START, st == ST_READ && in_chain)
  `TFE_ASSERT_NEXT(a_emit_loads_word, st == ST_EMIT && out_free, out_valid)
  `TFE_ASSERT_NOW(a_chain_bounded, 32'(chain_cnt) <= CHAIN_LIMIT)

endmodule
